>>> src/cicdec_pkg.sv
// Shared constants and types for the cascaded CIC5 I/Q decimator.
package cicdec_pkg;

  localparam int MAX_STAGES = 5;
  localparam int LANE_WIDTH = 16;
  localparam int SECTIONS   = 5;
  localparam int LANES      = 2;

  localparam int SAMPLE_WIDTH = 8;
  localparam int OUT_WIDTH    = 16;
  localparam int SHIFT_WIDTH  = 3;
  localparam int COUNT_WIDTH  = 3;
  localparam int ADDR_WIDTH   = 3;
  localparam int DATA_WIDTH   = 32;

  localparam int LANE_I = 0;
  localparam int LANE_Q = 1;

  // Byte addresses sit on a four-byte grid; bit 2 selects the register.
  localparam logic REG_INPUT_SIGNED = 1'b0;
  localparam logic REG_STAGE_COUNT  = 1'b1;

  localparam logic [COUNT_WIDTH-1:0] STAGE_MIN   = 3'd3;
  localparam logic [COUNT_WIDTH-1:0] STAGE_MAX   = COUNT_WIDTH'(MAX_STAGES);
  localparam logic [COUNT_WIDTH-1:0] STAGE_RESET = 3'd5;

  localparam logic [SHIFT_WIDTH-1:0] SHIFT_FIRST  = 3'd3;
  localparam logic [SHIFT_WIDTH-1:0] SHIFT_SECOND = 3'd4;
  localparam logic [SHIFT_WIDTH-1:0] SHIFT_MIDDLE = 3'd5;
  localparam logic [SHIFT_WIDTH-1:0] SHIFT_LAST   = 3'd0;

  localparam logic [SAMPLE_WIDTH-1:0] SAMPLE_SIGN = 8'h80;
  localparam logic [OUT_WIDTH-1:0]    OUT_SIGN    = 16'h8000;

  typedef logic [LANE_WIDTH-1:0]            lane_t;
  typedef logic [LANES-1:0][LANE_WIDTH-1:0] lanes_t;

  typedef struct packed {
    logic                   en;
    logic [SHIFT_WIDTH-1:0] shift;
  } stage_ctrl_t;

endpackage

>>> src/cicdec_stage.sv
// One polyphase (1+z^-1)^5 decimate-by-two stage for both lanes.
module cicdec_stage (
  input  logic                  clk,
  input  logic                  rst,
  input  cicdec_pkg::stage_ctrl_t ctrl,
  input  cicdec_pkg::lanes_t    x,
  output cicdec_pkg::lanes_t    y,
  output logic                  emit
);
  import cicdec_pkg::*;

  logic  phase;
  lane_t hold    [LANES][SECTIONS];
  lane_t partial [LANES][SECTIONS];
  lane_t z       [LANES][SECTIONS+1];

  // Even phase runs through the holds; odd phase runs through the partials.
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      z[l][0] = x[l];
      for (int k = 0; k < SECTIONS; k++) begin
        z[l][k+1] = z[l][k] + (phase ? partial[l][k] : hold[l][k]);
      end
      y[l] = z[l][SECTIONS] >> ctrl.shift;
    end
  end

  assign emit = ~phase;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= 1'b0;
      for (int l = 0; l < LANES; l++) begin
        for (int k = 0; k < SECTIONS; k++) begin
          hold[l][k] <= '0;
        end
      end
    end else if (ctrl.en) begin
      phase <= ~phase;
      if (phase) begin
        for (int l = 0; l < LANES; l++) begin
          for (int k = 0; k < SECTIONS; k++) begin
            hold[l][k] <= z[l][k];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.en && !phase) begin
      for (int l = 0; l < LANES; l++) begin
        for (int k = 0; k < SECTIONS; k++) begin
          partial[l][k] <= z[l][k];
        end
      end
    end
  end

endmodule

>>> src/iq_cic5_decimator_cascade.sv
// Top level of the cascaded CIC5 I/Q decimator with its register port.
// Path: an accepted sample that completes a decimated output passes one pipeline
// register per stage into the output register; n is stage_count clamped to 3..5.
// Throughput: one input transaction per cycle unless frozen; a result per 2^n inputs.
// The whole pipeline freezes only while a result waits and out_stall is high.
// Reset clears all section holds, stage phases and pipeline valids, and sets
// input_signed to 0 and stage_count to 5.
module iq_cic5_decimator_cascade (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [cicdec_pkg::ADDR_WIDTH-1:0]     paddr,
  input  logic [cicdec_pkg::DATA_WIDTH-1:0]     pwdata,
  output logic [cicdec_pkg::DATA_WIDTH-1:0]     prdata,
  output logic                                  pready,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [cicdec_pkg::SAMPLE_WIDTH-1:0]   i_sample,
  input  logic [cicdec_pkg::SAMPLE_WIDTH-1:0]   q_sample,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [cicdec_pkg::OUT_WIDTH-1:0] i_out,
  output logic signed [cicdec_pkg::OUT_WIDTH-1:0] q_out
);
  import cicdec_pkg::*;

  logic                   input_signed;
  logic [COUNT_WIDTH-1:0] stage_count;
  logic [COUNT_WIDTH-1:0] stage_eff;
  logic [COUNT_WIDTH-1:0] last;
  logic                   advance;
  logic                   cfg_write;

  logic [MAX_STAGES-1:0]  stage_valid;
  lanes_t                 stage_x [MAX_STAGES];
  lanes_t                 stage_y [MAX_STAGES];
  logic [MAX_STAGES-1:0]  stage_emit;
  logic [MAX_STAGES-1:0]  fire;
  logic [MAX_STAGES-1:0]  last_fire;
  logic [MAX_STAGES-1:0]  live_mask;
  lanes_t                 result_next;
  lanes_t                 sample_in;

  // Configuration port.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      input_signed <= 1'b0;
      stage_count  <= STAGE_RESET;
    end else if (cfg_write) begin
      case (paddr[2])
        REG_INPUT_SIGNED: input_signed <= pwdata[0];
        REG_STAGE_COUNT:  stage_count  <= pwdata[COUNT_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_INPUT_SIGNED: prdata = {{(DATA_WIDTH-1){1'b0}}, input_signed};
      REG_STAGE_COUNT:  prdata = {{(DATA_WIDTH-COUNT_WIDTH){1'b0}}, stage_count};
      default:          prdata = '0;
    endcase
  end

  always_comb begin
    if (stage_count < STAGE_MIN) begin
      stage_eff = STAGE_MIN;
    end else if (stage_count > STAGE_MAX) begin
      stage_eff = STAGE_MAX;
    end else begin
      stage_eff = stage_count;
    end
  end
  assign last = stage_eff - COUNT_WIDTH'(1);

  // The pipeline moves whenever the output register is free or being emptied.
  assign advance  = !out_valid || !out_stall;
  assign in_stall = !advance;

  always_comb begin
    sample_in[LANE_I] = LANE_WIDTH'(i_sample ^ (input_signed ? SAMPLE_SIGN : '0));
    sample_in[LANE_Q] = LANE_WIDTH'(q_sample ^ (input_signed ? SAMPLE_SIGN : '0));
  end

  for (genvar s = 0; s < MAX_STAGES; s++) begin : g_stage
    stage_ctrl_t ctrl;

    always_comb begin
      ctrl.en = advance && stage_valid[s];
      if (COUNT_WIDTH'(s) == last) begin
        ctrl.shift = SHIFT_LAST;
      end else if (s == 0) begin
        ctrl.shift = SHIFT_FIRST;
      end else if (s == 1) begin
        ctrl.shift = SHIFT_SECOND;
      end else begin
        ctrl.shift = SHIFT_MIDDLE;
      end
    end

    cicdec_stage u_stage (
      .clk  (clk),
      .rst  (rst),
      .ctrl (ctrl),
      .x    (stage_x[s]),
      .y    (stage_y[s]),
      .emit (stage_emit[s])
    );

    assign fire[s]      = stage_valid[s] && stage_emit[s];
    assign last_fire[s] = fire[s] && (COUNT_WIDTH'(s) == last);
    assign live_mask[s] = COUNT_WIDTH'(s) <= last;

    if (s == 0) begin : g_head
      always_ff @(posedge clk) begin
        if (rst) begin
          stage_valid[s] <= 1'b0;
        end else if (advance) begin
          stage_valid[s] <= in_valid;
        end
      end
      always_ff @(posedge clk) begin
        if (advance && in_valid) begin
          stage_x[s] <= sample_in;
        end
      end
    end else begin : g_link
      always_ff @(posedge clk) begin
        if (rst) begin
          stage_valid[s] <= 1'b0;
        end else if (advance) begin
          stage_valid[s] <= fire[s-1] && (COUNT_WIDTH'(s-1) < last);
        end
      end
      always_ff @(posedge clk) begin
        if (advance && fire[s-1]) begin
          stage_x[s] <= stage_y[s-1];
        end
      end
    end
  end

  always_comb begin
    result_next = '0;
    for (int s = 0; s < MAX_STAGES; s++) begin
      if (COUNT_WIDTH'(s) == last) begin
        result_next = stage_y[s];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= |last_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && |last_fire) begin
      i_out <= OUT_WIDTH'(result_next[LANE_I]) ^ OUT_SIGN;
      q_out <= OUT_WIDTH'(result_next[LANE_Q]) ^ OUT_SIGN;
    end
  end

  // No transaction ever reaches a stage past the configured last one.
  a_no_dead_stage: assert property (@(posedge clk) disable iff (rst)
    (stage_valid & ~live_mask) == '0)
    else $error("transaction present in a stage beyond the last stage");

  // A frozen pipeline keeps its occupancy.
  a_freeze_holds: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(stage_valid))
    else $error("pipeline moved while the output was stalled");

  // A new result only follows the last stage firing on its even phase.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !$past(out_valid)) |-> $past(|last_fire))
    else $error("result appeared without the last stage firing");

endmodule

>>> sim/tb_top.sv
// Self-checking testbench for the cascaded CIC5 I/Q decimator.
`timescale 1ns / 100ps

module tb_top;
  import cicdec_pkg::*;

  localparam int LIMIT_CYCLES  = 400000;
  localparam int SETTLE_CYCLES = 2 * MAX_STAGES + 4;
  localparam int RX_LONG_HOLD  = 400;
  localparam int ITEM_TARGET   = 1850;
  localparam int OUTPUT_TARGET = 48;
  localparam int PHASE_ITEMS   = 230;
  localparam int NUM_DIRECTED  = 24;

  localparam logic [ADDR_WIDTH-1:0] ADDR_INPUT_SIGNED = {REG_INPUT_SIGNED, 2'b00};
  localparam logic [ADDR_WIDTH-1:0] ADDR_STAGE_COUNT  = {REG_STAGE_COUNT, 2'b00};

  typedef enum int {PAT_NOISE, PAT_EXTREME, PAT_STEADY, PAT_TOGGLE} sig_pattern_t;

  typedef struct packed {
    logic [OUT_WIDTH-1:0] i_val;
    logic [OUT_WIDTH-1:0] q_val;
  } iq_pair_t;

  typedef struct packed {
    logic                    sgn;
    logic [COUNT_WIDTH-1:0]  stages;
    logic [SAMPLE_WIDTH-1:0] ib;
    logic [SAMPLE_WIDTH-1:0] qb;
    logic                    typed;
    iq_pair_t                want;
  } dir_vec_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_WIDTH-1:0] paddr = '0;
  logic [DATA_WIDTH-1:0] pwdata = '0;
  logic [DATA_WIDTH-1:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [SAMPLE_WIDTH-1:0] i_sample = '0;
  logic [SAMPLE_WIDTH-1:0] q_sample = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [OUT_WIDTH-1:0] i_out;
  logic signed [OUT_WIDTH-1:0] q_out;

  iq_cic5_decimator_cascade dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall), .i_sample(i_sample), .q_sample(q_sample),
    .out_valid(out_valid), .out_stall(out_stall), .i_out(i_out), .q_out(q_out)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predictor state: one copy of every section hold, even-phase partial and phase.
  lane_t hold_r [MAX_STAGES][LANES][SECTIONS];
  lane_t part_r [MAX_STAGES][LANES][SECTIONS];
  bit    phase_r [MAX_STAGES];
  logic  cfg_signed = 1'b0;
  logic [COUNT_WIDTH-1:0] cfg_stages = STAGE_RESET;

  iq_pair_t decimated_due [$];
  iq_pair_t want_now;

  int error_count = 0;
  int items_sent = 0;
  int outputs_checked = 0;
  int config_phases = 0;
  int input_blocked = 0;
  int cycle_count = 0;
  int hold_requests = 0;
  int holds_served = 0;
  int rx_stall_left = 0;
  int rx_free_left = 0;
  int rx_roll;
  int tx_calm_left = 0;

  dir_vec_t dir_vecs [NUM_DIRECTED] = '{
    '{1'b0, 3'd5, 8'hFF, 8'h00, 1'b1, '{16'h8000, 16'h8000}},
    '{1'b0, 3'd5, 8'hFF, 8'hFF, 1'b0, '0},
    '{1'b0, 3'd5, 8'h00, 8'h00, 1'b0, '0},
    '{1'b0, 3'd5, 8'h80, 8'h7F, 1'b0, '0},
    '{1'b0, 3'd5, 8'h7F, 8'h80, 1'b0, '0},
    '{1'b0, 3'd5, 8'h01, 8'hFE, 1'b0, '0},
    '{1'b0, 3'd5, 8'hAA, 8'h55, 1'b0, '0},
    '{1'b0, 3'd5, 8'h55, 8'hAA, 1'b0, '0},
    '{1'b1, 3'd3, 8'h80, 8'h80, 1'b0, '0},
    '{1'b1, 3'd3, 8'h7F, 8'h7F, 1'b0, '0},
    '{1'b1, 3'd3, 8'h00, 8'hFF, 1'b0, '0},
    '{1'b1, 3'd3, 8'hFF, 8'h00, 1'b0, '0},
    '{1'b1, 3'd3, 8'h80, 8'h7F, 1'b0, '0},
    '{1'b1, 3'd3, 8'h7F, 8'h80, 1'b0, '0},
    '{1'b1, 3'd3, 8'h00, 8'h00, 1'b0, '0},
    '{1'b1, 3'd3, 8'h01, 8'h01, 1'b0, '0},
    '{1'b0, 3'd0, 8'hFF, 8'hFF, 1'b0, '0},
    '{1'b0, 3'd0, 8'hFF, 8'hFF, 1'b0, '0},
    '{1'b0, 3'd2, 8'h00, 8'hFF, 1'b0, '0},
    '{1'b0, 3'd2, 8'hFF, 8'h00, 1'b0, '0},
    '{1'b1, 3'd7, 8'h80, 8'h7F, 1'b0, '0},
    '{1'b1, 3'd7, 8'h7F, 8'h80, 1'b0, '0},
    '{1'b1, 3'd6, 8'hFF, 8'hFF, 1'b0, '0},
    '{1'b1, 3'd6, 8'h00, 8'h00, 1'b0, '0}
  };

  logic [COUNT_WIDTH-1:0] stage_plan [8] = '{3'd3, 3'd5, 3'd0, 3'd7, 3'd4, 3'd1, 3'd2, 3'd6};

  function automatic void flag_error(input string msg);
    error_count++;
    if (error_count <= 10) $display("ERROR at %0t: %s", $time, msg);
  endfunction

  // Runs one sample through the cascade; returns 1 when the last stage emits.
  function automatic bit cic_step(input logic [SAMPLE_WIDTH-1:0] ib, qb,
                                  output lane_t yi, yq);
    lane_t x [LANES];
    lane_t z;
    int n;
    int sh;
    n = (cfg_stages < STAGE_MIN) ? STAGE_MIN :
        (cfg_stages > STAGE_MAX) ? STAGE_MAX : cfg_stages;
    x[LANE_I] = lane_t'(cfg_signed ? (ib ^ SAMPLE_SIGN) : ib);
    x[LANE_Q] = lane_t'(cfg_signed ? (qb ^ SAMPLE_SIGN) : qb);
    for (int s = 0; s < n; s++) begin
      if (!phase_r[s]) begin
        sh = (s == n - 1) ? SHIFT_LAST : (s == 0) ? SHIFT_FIRST :
             (s == 1) ? SHIFT_SECOND : SHIFT_MIDDLE;
        for (int l = 0; l < LANES; l++) begin
          z = x[l];
          for (int k = 0; k < SECTIONS; k++) begin
            part_r[s][l][k] = z;
            z = z + hold_r[s][l][k];
          end
          x[l] = z >> sh;
        end
        phase_r[s] = 1'b1;
      end else begin
        // The odd phase only refreshes the holds; nothing moves downstream.
        for (int l = 0; l < LANES; l++) begin
          z = x[l];
          for (int k = 0; k < SECTIONS; k++) begin
            hold_r[s][l][k] = z;
            z = z + part_r[s][l][k];
          end
        end
        phase_r[s] = 1'b0;
        return 1'b0;
      end
    end
    yi = x[LANE_I] ^ OUT_SIGN;
    yq = x[LANE_Q] ^ OUT_SIGN;
    return 1'b1;
  endfunction

  function automatic logic [SAMPLE_WIDTH-1:0] extreme_byte();
    case ($urandom_range(0, 3))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h80;
      default: return 8'h7F;
    endcase
  endfunction

  function automatic int next_gap();
    int r;
    if (tx_calm_left > 0) begin
      tx_calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) tx_calm_left = $urandom_range(40, 150);
    else if (r < 9) return $urandom_range(8, 30);
    else if (r < 30) return $urandom_range(1, 3);
    return 0;
  endfunction

  task automatic drop_valid();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_results();
    while (decimated_due.size() != 0) @(posedge clk);
  endtask

  task automatic send_item(input logic [SAMPLE_WIDTH-1:0] ib, qb, input logic typed,
                           input iq_pair_t typed_val);
    lane_t pi;
    lane_t pq;
    iq_pair_t due;
    int gap;
    gap = next_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    i_sample <= ib;
    q_sample <= qb;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    if (cic_step(ib, qb, pi, pq)) begin
      due = typed ? typed_val : iq_pair_t'{pi, pq};
      decimated_due.push_back(due);
    end
  endtask

  task automatic reg_write(input logic [ADDR_WIDTH-1:0] addr, input logic [DATA_WIDTH-1:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Registers only change with the pipeline empty, so the predictor can switch at once.
  task automatic apply_config(input logic sg, input logic [COUNT_WIDTH-1:0] sc);
    drop_valid();
    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    reg_write(ADDR_INPUT_SIGNED, ($urandom & ~32'h1) | DATA_WIDTH'(sg));
    reg_write(ADDR_STAGE_COUNT, ($urandom & ~32'h7) | DATA_WIDTH'(sc));
    cfg_signed = sg;
    cfg_stages = sc;
    config_phases++;
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (decimated_due.size() == 0) begin
        flag_error($sformatf("result with nothing expected: i=%0d q=%0d", i_out, q_out));
      end else begin
        want_now = decimated_due.pop_front();
        outputs_checked++;
        if (i_out !== want_now.i_val)
          flag_error($sformatf("i_out expected %0d got %0d",
                               $signed(want_now.i_val), i_out));
        if (q_out !== want_now.q_val)
          flag_error($sformatf("q_out expected %0d got %0d",
                               $signed(want_now.q_val), q_out));
      end
    end
  end

  // Output side back-pressure, including the long hold the sender asks for.
  always @(negedge clk) begin
    if (hold_requests != holds_served) begin
      holds_served++;
      rx_stall_left = RX_LONG_HOLD;
      rx_free_left = 0;
    end
    if (rx_stall_left > 0) begin
      out_stall <= 1'b1;
      rx_stall_left--;
    end else if (rx_free_left > 0) begin
      out_stall <= 1'b0;
      rx_free_left--;
    end else begin
      out_stall <= 1'b0;
      rx_roll = $urandom_range(0, 99);
      if (rx_roll < 6) rx_free_left = $urandom_range(40, 150);
      else if (rx_roll < 12) rx_stall_left = $urandom_range(8, 30);
      else if (rx_roll < 45) rx_stall_left = $urandom_range(1, 3);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (in_valid && in_stall) input_blocked <= input_blocked + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("Run stopped at the cycle limit with %0d results outstanding",
               decimated_due.size());
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int plan_idx;
    int run_left;
    sig_pattern_t pat;
    logic sg;
    logic [COUNT_WIDTH-1:0] sc;
    logic [SAMPLE_WIDTH-1:0] ib, qb, base_i, base_q;
    plan_idx = 0;
    run_left = 0;
    pat = PAT_NOISE;
    base_i = '0;
    base_q = '0;
    for (int s = 0; s < MAX_STAGES; s++) begin
      phase_r[s] = 1'b0;
      for (int l = 0; l < LANES; l++)
        for (int k = 0; k < SECTIONS; k++) begin
          hold_r[s][l][k] = '0;
          part_r[s][l][k] = '0;
        end
    end
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // Directed rows; the first one runs with the reset configuration.
    for (int v = 0; v < NUM_DIRECTED; v++) begin
      if (dir_vecs[v].sgn != cfg_signed || dir_vecs[v].stages != cfg_stages)
        apply_config(dir_vecs[v].sgn, dir_vecs[v].stages);
      send_item(dir_vecs[v].ib, dir_vecs[v].qb, dir_vecs[v].typed, dir_vecs[v].want);
    end

    while (items_sent < ITEM_TARGET || outputs_checked < OUTPUT_TARGET) begin
      if (plan_idx < 8) begin
        sg = plan_idx[0];
        sc = stage_plan[plan_idx];
      end else begin
        sg = $urandom_range(0, 1);
        sc = $urandom_range(0, 7);
      end
      apply_config(sg, sc);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if ((plan_idx == 1 && k == 40) || (plan_idx == 4 && k == 100)) hold_requests++;
        if (plan_idx == 2 && k == 120) begin
          drop_valid();
          wait_results();
        end
        if (run_left == 0) begin
          pat = sig_pattern_t'($urandom_range(0, 3));
          run_left = $urandom_range(4, 48);
          base_i = $urandom;
          base_q = $urandom;
        end
        run_left--;
        case (pat)
          PAT_NOISE: begin
            ib = $urandom;
            qb = $urandom;
          end
          PAT_EXTREME: begin
            ib = extreme_byte();
            qb = extreme_byte();
          end
          PAT_STEADY: begin
            ib = base_i;
            qb = base_q;
          end
          PAT_TOGGLE: begin
            base_i = ~base_i;
            base_q = ~base_q;
            ib = base_i;
            qb = base_q;
          end
        endcase
        send_item(ib, qb, 1'b0, '0);
      end
      plan_idx++;
    end

    drop_valid();
    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Checked %0d decimated outputs from %0d samples over %0d register settings.",
             outputs_checked, items_sent, config_phases);
    $display("Stage counts 0 to 7, both input formats; input held back for %0d cycles.",
             input_blocked);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches in total", error_count);
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/cicdec_pkg.sv
src/cicdec_stage.sv
src/iq_cic5_decimator_cascade.sv
sim/tb_top.sv
